FILE: src/iou_pkg.sv
// Shared types and constants of the overlap box tracker.
package iou_pkg;

   // Controller states, one-hot.
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_READ  = 9'b000000010,
      S_GEOM  = 9'b000000100,
      S_CMPW  = 9'b000001000,
      S_DONE  = 9'b000010000,
      S_FREAD = 9'b000100000,
      S_FDEC  = 9'b001000000,
      S_FEND  = 9'b010000000,
      S_SPARE = 9'b100000000
   } state_type;

   // Result status codes.
   localparam logic [2:0] ST_MATCHED = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_DROPPED = 3'd2;
   localparam logic [2:0] ST_LIVE = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   // Input kinds.
   localparam logic KIND_DETECT = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MATCH_CREDIT = 2'd1;
   localparam logic [1:0] CSR_NEW_CREDIT = 2'd2;

   localparam int THR_BITS = 7;
   localparam int CRED_ADD_BITS = 4;
   localparam int CREDIT_BITS = 8;
   localparam int SLOT_OUT_BITS = 4;

   localparam logic [THR_BITS-1:0] THR_RESET = 7'd80;
   localparam logic [CRED_ADD_BITS-1:0] MATCH_CREDIT_RESET = 4'd2;
   localparam logic [CRED_ADD_BITS-1:0] NEW_CREDIT_RESET = 4'd2;
   localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = 8'hFF;
   localparam logic [THR_BITS-1:0] PCT_SCALE = 7'd100;

   // Handshake from the overlap unit back to the controller.
   typedef struct packed {
      logic done;
      logic hit;
   } geom_stat_type;

endpackage

FILE: src/iou_box_tracker.sv
// Top level of the overlap box tracker: slot table, sequencer and result port.
// Detection: the walk reads each slot in turn and runs the overlap test on each live one, stopping at the first hit;
//   the walk is bounded by the one-read-per-cycle slot memories and the 3-stage overlap unit.
// Frame end: every live slot's credit is decremented; one report per survivor, or one empty report if none survive.
// One transaction is in work at a time; a finished result waits in the output register.
// Synchronous reset frees all slots at once (per-slot live bits); box memory is not cleared.
module iou_box_tracker #(
   parameter int TABLE_SLOTS = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // detection / frame-end transactions
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [COORD_BITS-1:0]                 req_pos_x,
   input  logic [COORD_BITS-1:0]                 req_pos_y,
   input  logic [COORD_BITS-1:0]                 req_size_w,
   input  logic [COORD_BITS-1:0]                 req_size_h,
   // result transactions
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_status,
   output logic [iou_pkg::SLOT_OUT_BITS-1:0]     rsp_slot,
   output logic [COORD_BITS-1:0]                 rsp_box_x,
   output logic [COORD_BITS-1:0]                 rsp_box_y,
   output logic [COORD_BITS-1:0]                 rsp_box_w,
   output logic [COORD_BITS-1:0]                 rsp_box_h,
   output logic [iou_pkg::CREDIT_BITS-1:0]       rsp_credit,
   output logic                                  rsp_last,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [iou_pkg::THR_BITS-1:0]          csr_wdata
);

   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int BW = 4 * COORD_BITS;
   localparam int CB = iou_pkg::CREDIT_BITS;
   localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);

   iou_pkg::state_type state_ff;

   // Configuration.
   logic [iou_pkg::THR_BITS-1:0]      threshold_ff;
   logic [iou_pkg::CRED_ADD_BITS-1:0] match_credit_ff;
   logic [iou_pkg::CRED_ADD_BITS-1:0] new_credit_ff;

   // Slot table: box and credit memories, live bits in flops.
   logic [BW-1:0] box_mem [TABLE_SLOTS];
   logic [CB-1:0] cred_mem [TABLE_SLOTS];
   logic [BW-1:0] box_rd_ff;
   logic [CB-1:0] cred_rd_ff;
   logic [TABLE_SLOTS-1:0] live_ff;

   // Transaction being worked.
   logic [COORD_BITS-1:0] det_x_ff, det_y_ff, det_w_ff, det_h_ff;
   logic [SW-1:0] idx_ff, free_idx_ff;
   logic free_found_ff, hit_ff;

   // Held survivor report; its last flag is known only once the walk moves on.
   logic pend_valid_ff;
   logic [SW-1:0] pend_slot_ff;
   logic [BW-1:0] pend_box_ff;
   logic [CB-1:0] pend_credit_ff;

   // Output register.
   logic rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [SW-1:0] rsp_slot_ff;
   logic [BW-1:0] rsp_box_ff;
   logic [CB-1:0] rsp_credit_ff;
   logic rsp_last_ff;

   iou_pkg::geom_stat_type geom_stat;

   logic out_free, idx_last, done_go, fdec_go, rd_en, cred_we, box_we, dec_zero;
   logic rsp_load;
   logic [SW-1:0] wr_addr;
   logic [CB-1:0] cred_wdata, match_c, ins_c, dec_c;
   logic [CB:0]   match_sum;
   logic [BW-1:0] det_box;

   assign det_box = {det_x_ff, det_y_ff, det_w_ff, det_h_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_last = (idx_ff == LAST_IDX);

   always_comb begin
      match_sum = {1'b0, cred_rd_ff} + (CB + 1)'(match_credit_ff);
      match_c = match_sum[CB] ? iou_pkg::CREDIT_MAX : match_sum[CB-1:0];
      ins_c = (new_credit_ff == '0) ? CB'(1) : CB'(new_credit_ff);
      dec_c = cred_rd_ff - CB'(1);
      dec_zero = (dec_c == '0);
      done_go = (state_ff == iou_pkg::S_DONE) && out_free;
      // stall a survivor only when the held report cannot move out
      fdec_go = (state_ff == iou_pkg::S_FDEC) && (dec_zero || !pend_valid_ff || out_free);
      // output register takes a new result this cycle
      rsp_load = done_go || (fdec_go && !dec_zero && pend_valid_ff)
                 || ((state_ff == iou_pkg::S_FEND) && out_free);
      rd_en = ((state_ff == iou_pkg::S_READ) || (state_ff == iou_pkg::S_FREAD))
              && live_ff[idx_ff];
      box_we = done_go && (hit_ff || free_found_ff);
      cred_we = box_we || fdec_go;
      wr_addr = ((state_ff == iou_pkg::S_DONE) && !hit_ff) ? free_idx_ff : idx_ff;
      if (state_ff == iou_pkg::S_FDEC) begin
         cred_wdata = dec_c;
      end else if (hit_ff) begin
         cred_wdata = match_c;
      end else begin
         cred_wdata = ins_c;
      end
   end

   // Slot memories: one write and one registered read per cycle. The sequencer
   // never reads a slot in the cycle it writes it, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[wr_addr] <= det_box;
      end
      if (cred_we) begin
         cred_mem[wr_addr] <= cred_wdata;
      end
      if (rd_en) begin
         box_rd_ff <= box_mem[idx_ff];
         cred_rd_ff <= cred_mem[idx_ff];
      end
   end

   iou_geom #(
      .COORD_BITS(COORD_BITS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == iou_pkg::S_GEOM),
      .det_x     (det_x_ff),
      .det_y     (det_y_ff),
      .det_w     (det_w_ff),
      .det_h     (det_h_ff),
      .box_x     (box_rd_ff[4*COORD_BITS-1:3*COORD_BITS]),
      .box_y     (box_rd_ff[3*COORD_BITS-1:2*COORD_BITS]),
      .box_w     (box_rd_ff[2*COORD_BITS-1:COORD_BITS]),
      .box_h     (box_rd_ff[COORD_BITS-1:0]),
      .threshold (threshold_ff),
      .stat      (geom_stat)
   );

   // Configuration writes; the user must write them only while the tracker is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= iou_pkg::THR_RESET;
         match_credit_ff <= iou_pkg::MATCH_CREDIT_RESET;
         new_credit_ff <= iou_pkg::NEW_CREDIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            iou_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            iou_pkg::CSR_MATCH_CREDIT: match_credit_ff <= csr_wdata[iou_pkg::CRED_ADD_BITS-1:0];
            iou_pkg::CSR_NEW_CREDIT: new_credit_ff <= csr_wdata[iou_pkg::CRED_ADD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input capture.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         det_x_ff <= req_pos_x;
         det_y_ff <= req_pos_y;
         det_w_ff <= req_size_w;
         det_h_ff <= req_size_h;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iou_pkg::S_IDLE;
         live_ff <= '0;
         idx_ff <= '0;
         free_idx_ff <= '0;
         free_found_ff <= 1'b0;
         hit_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            iou_pkg::S_IDLE: begin
               if (req_valid) begin
                  idx_ff <= '0;
                  free_found_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  state_ff <= (req_kind == iou_pkg::KIND_FRAME_END) ?
                              iou_pkg::S_FREAD : iou_pkg::S_READ;
               end
            end
            iou_pkg::S_READ: begin
               if (live_ff[idx_ff]) begin
                  state_ff <= iou_pkg::S_GEOM;
               end else begin
                  // remember the lowest free slot
                  if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff <= idx_ff;
                  end
                  if (idx_last) begin
                     state_ff <= iou_pkg::S_DONE;
                  end else begin
                     idx_ff <= idx_ff + SW'(1);
                  end
               end
            end
            iou_pkg::S_GEOM: begin
               state_ff <= iou_pkg::S_CMPW;
            end
            iou_pkg::S_CMPW: begin
               if (geom_stat.done) begin
                  if (geom_stat.hit) begin
                     hit_ff <= 1'b1;
                     state_ff <= iou_pkg::S_DONE;
                  end else if (idx_last) begin
                     state_ff <= iou_pkg::S_DONE;
                  end else begin
                     idx_ff <= idx_ff + SW'(1);
                     state_ff <= iou_pkg::S_READ;
                  end
               end
            end
            iou_pkg::S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_box_ff <= det_box;
                  rsp_last_ff <= 1'b1;
                  if (hit_ff) begin
                     rsp_status_ff <= iou_pkg::ST_MATCHED;
                     rsp_slot_ff <= idx_ff;
                     rsp_credit_ff <= match_c;
                  end else if (free_found_ff) begin
                     rsp_status_ff <= iou_pkg::ST_INSERTED;
                     rsp_slot_ff <= free_idx_ff;
                     rsp_credit_ff <= ins_c;
                     live_ff[free_idx_ff] <= 1'b1;
                  end else begin
                     rsp_status_ff <= iou_pkg::ST_DROPPED;
                     rsp_slot_ff <= '0;
                     rsp_credit_ff <= '0;
                  end
                  state_ff <= iou_pkg::S_IDLE;
               end
            end
            iou_pkg::S_FREAD: begin
               if (live_ff[idx_ff]) begin
                  state_ff <= iou_pkg::S_FDEC;
               end else if (idx_last) begin
                  state_ff <= iou_pkg::S_FEND;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
               end
            end
            iou_pkg::S_FDEC: begin
               if (fdec_go) begin
                  if (dec_zero) begin
                     live_ff[idx_ff] <= 1'b0;
                  end else begin
                     // release the previous survivor, hold this one
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_status_ff <= iou_pkg::ST_LIVE;
                        rsp_slot_ff <= pend_slot_ff;
                        rsp_box_ff <= pend_box_ff;
                        rsp_credit_ff <= pend_credit_ff;
                        rsp_last_ff <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_slot_ff <= idx_ff;
                     pend_box_ff <= box_rd_ff;
                     pend_credit_ff <= dec_c;
                  end
                  if (idx_last) begin
                     state_ff <= iou_pkg::S_FEND;
                  end else begin
                     idx_ff <= idx_ff + SW'(1);
                     state_ff <= iou_pkg::S_FREAD;
                  end
               end
            end
            iou_pkg::S_FEND: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff <= 1'b1;
                  if (pend_valid_ff) begin
                     rsp_status_ff <= iou_pkg::ST_LIVE;
                     rsp_slot_ff <= pend_slot_ff;
                     rsp_box_ff <= pend_box_ff;
                     rsp_credit_ff <= pend_credit_ff;
                  end else begin
                     rsp_status_ff <= iou_pkg::ST_EMPTY;
                     rsp_slot_ff <= '0;
                     rsp_box_ff <= '0;
                     rsp_credit_ff <= '0;
                  end
                  pend_valid_ff <= 1'b0;
                  state_ff <= iou_pkg::S_IDLE;
               end
            end
            default: begin
               state_ff <= iou_pkg::S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == iou_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = iou_pkg::SLOT_OUT_BITS'(rsp_slot_ff);
   assign rsp_box_x = rsp_box_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign rsp_box_y = rsp_box_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign rsp_box_w = rsp_box_ff[2*COORD_BITS-1:COORD_BITS];
   assign rsp_box_h = rsp_box_ff[COORD_BITS-1:0];
   assign rsp_credit = rsp_credit_ff;
   assign rsp_last = rsp_last_ff;

   // A held survivor report never outlives its frame-end walk.
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iou_pkg::S_IDLE) |-> !pend_valid_ff)
      else $error("survivor report held while idle");

   // The overlap unit reports only while the sequencer waits for it.
   a_geom_done: assert property (@(posedge clock) disable iff (reset)
      geom_stat.done |-> (state_ff == iou_pkg::S_CMPW))
      else $error("overlap result outside compare wait");

   // An inserted box is live afterwards.
   a_insert_live: assert property (@(posedge clock) disable iff (reset)
      (done_go && !hit_ff && free_found_ff) |=> live_ff[$past(free_idx_ff)])
      else $error("inserted slot not live");

   // Matched and inserted results always carry a nonzero credit.
   a_credit_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_status_ff == iou_pkg::ST_MATCHED)
                        || (rsp_status_ff == iou_pkg::ST_INSERTED)))
      |-> (rsp_credit_ff != '0))
      else $error("live result with zero credit");

endmodule

FILE: src/iou_geom.sv
// Three-stage overlap test: intersection vs. bounding area against a percent threshold.
module iou_geom #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COORD_BITS-1:0]             det_x,
   input  logic [COORD_BITS-1:0]             det_y,
   input  logic [COORD_BITS-1:0]             det_w,
   input  logic [COORD_BITS-1:0]             det_h,
   input  logic [COORD_BITS-1:0]             box_x,
   input  logic [COORD_BITS-1:0]             box_y,
   input  logic [COORD_BITS-1:0]             box_w,
   input  logic [COORD_BITS-1:0]             box_h,
   input  logic [iou_pkg::THR_BITS-1:0]      threshold,
   output iou_pkg::geom_stat_type            stat
);

   localparam int EW = COORD_BITS + 1;
   localparam int PW = 2 * EW;
   localparam int LW = PW + iou_pkg::THR_BITS;

   logic [EW-1:0] dr, br, db, bb;
   logic [EW-1:0] il, ir, it, ib, ul, ur, ut, ub;
   logic [EW-1:0] iw, ih, bw, bh;
   logic [EW-1:0] iw_ff, ih_ff, bw_ff, bh_ff;
   logic [PW-1:0] inter_ff, bound_ff;
   logic [LW-1:0] lhs_ff, rhs_ff;
   logic v1_ff, v2_ff, v3_ff;

   always_comb begin
      dr = EW'(det_x) + EW'(det_w);
      br = EW'(box_x) + EW'(box_w);
      db = EW'(det_y) + EW'(det_h);
      bb = EW'(box_y) + EW'(box_h);
      il = (det_x > box_x) ? EW'(det_x) : EW'(box_x);
      ul = (det_x < box_x) ? EW'(det_x) : EW'(box_x);
      it = (det_y > box_y) ? EW'(det_y) : EW'(box_y);
      ut = (det_y < box_y) ? EW'(det_y) : EW'(box_y);
      ir = (dr < br) ? dr : br;
      ur = (dr > br) ? dr : br;
      ib = (db < bb) ? db : bb;
      ub = (db > bb) ? db : bb;
      iw = (ir > il) ? ir - il : '0;
      ih = (ib > it) ? ib - it : '0;
      bw = ur - ul;
      bh = ub - ut;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         iw_ff <= iw;
         ih_ff <= ih;
         bw_ff <= bw;
         bh_ff <= bh;
      end
      if (v1_ff) begin
         inter_ff <= PW'(iw_ff) * PW'(ih_ff);
         bound_ff <= PW'(bw_ff) * PW'(bh_ff);
      end
      if (v2_ff) begin
         lhs_ff <= LW'(inter_ff) * LW'(iou_pkg::PCT_SCALE);
         rhs_ff <= LW'(bound_ff) * LW'(threshold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign stat.done = v3_ff;
   assign stat.hit = lhs_ff > rhs_ff;

endmodule
